@@ hw/rtl/integer_literal_parser_assert.svh @@
// Assertion macros for the integer literal parser.
// Expects signals clk and rst in the scope of each use; empty under SYNTHESIS.
`ifndef INTEGER_LITERAL_PARSER_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
`define ILP_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("integer_literal_parser: assertion failed");
`define ILP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("integer_literal_parser: assertion failed");
`else
`define ILP_ASSERT(label, ante, cons)
`define ILP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hw/rtl/ilp_pkg.sv @@
// Types and character codes for the integer literal parser.
// No dependencies.
package ilp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ZERO = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_OCT = 2'd2,
    BASE_BIN = 2'd3
  } base_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  localparam logic [15:0] LEN_MAX = 16'hffff;

endpackage

@@ hw/rtl/integer_literal_parser.sv @@
// Streaming integer literal parser with radix prefix, top level.
// Depends on ilp_pkg and integer_literal_parser_assert.svh.
//
// Takes one character per cycle on the char channel while no result is stalled,
// and returns one result request per terminated literal on the result channel.
// A character is captured in an input register; from there its state update (a
// shift or shift-add of the 64-bit accumulator plus the digit) and any result
// are registered, so a result shows in the result register after its terminator
// has passed the input register. The accumulator update sets the rate; a
// stalled result holds the input register and then the char channel. The mode
// register is written through the cfg channel, which is always ready.
`include "integer_literal_parser_assert.svh"

module integer_literal_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  ch,
  input  logic        first_char,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] value,
  output logic [1:0]  base_code,
  output logic [15:0] length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        leading_zero_octal
);
  import ilp_pkg::*;

  logic        zero_octal_mode;
  logic        hold_valid;
  logic [7:0]  hold_ch;
  logic        hold_first;

  phase_t      phase, phase_next;
  logic [63:0] accumulator, accumulator_next;
  base_t       base_sel, base_sel_next;
  logic [15:0] char_count, char_count_next;

  logic        advance;
  logic        out_free;
  logic        emit;
  logic        run_body;
  logic [63:0] eff_acc;
  base_t       eff_base;
  logic [15:0] eff_cnt;
  logic        is_digit;
  logic [3:0]  digit;
  logic [63:0] scaled;
  logic [15:0] cnt_inc;

  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;
  assign advance    = hold_valid && out_free;
  assign char_stall = hold_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_octal_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      zero_octal_mode <= leading_zero_octal;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!char_stall) begin
      hold_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      hold_ch    <= ch;
      hold_first <= first_char;
    end
  end

  always_comb begin
    is_digit = 1'b1;
    digit    = 4'd0;
    if (hold_ch >= CH_ZERO && hold_ch <= CH_NINE) begin
      digit = 4'(hold_ch - CH_ZERO);
    end else if (hold_ch >= CH_LA && hold_ch <= CH_LF) begin
      digit = 4'(hold_ch - CH_LA + 8'd10);
    end else if (hold_ch >= CH_UA && hold_ch <= CH_UF) begin
      digit = 4'(hold_ch - CH_UA + 8'd10);
    end else begin
      is_digit = 1'b0;
    end
  end

  // Resolve the state the body step works from.
  always_comb begin
    phase_next       = phase;
    accumulator_next = accumulator;
    base_sel_next    = base_sel;
    char_count_next  = char_count;
    run_body         = 1'b0;
    eff_acc          = accumulator;
    eff_base         = base_sel;
    eff_cnt          = char_count;
    if (hold_first) begin
      eff_acc  = '0;
      eff_base = BASE_DEC;
      eff_cnt  = '0;
      if (hold_ch == CH_ZERO) begin
        phase_next       = PH_ZERO;
        accumulator_next = '0;
        base_sel_next    = BASE_DEC;
        char_count_next  = 16'd1;
      end else begin
        run_body = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_ZERO: begin
          if (hold_ch == CH_X || hold_ch == CH_O || hold_ch == CH_B) begin
            phase_next      = PH_BODY;
            char_count_next = 16'd2;
            if (hold_ch == CH_X) begin
              base_sel_next = BASE_HEX;
            end else if (hold_ch == CH_O) begin
              base_sel_next = BASE_OCT;
            end else begin
              base_sel_next = BASE_BIN;
            end
          end else begin
            eff_base = zero_octal_mode ? BASE_OCT : BASE_DEC;
            run_body = 1'b1;
          end
        end
        PH_BODY: run_body = 1'b1;
        default: run_body = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (eff_base)
      BASE_HEX: scaled = {eff_acc[59:0], 4'b0};
      BASE_OCT: scaled = {eff_acc[60:0], 3'b0};
      BASE_BIN: scaled = {eff_acc[62:0], 1'b0};
      default:  scaled = {eff_acc[60:0], 3'b0} + {eff_acc[62:0], 1'b0};
    endcase
  end

  assign cnt_inc = (eff_cnt == LEN_MAX) ? eff_cnt : eff_cnt + 16'd1;
  assign emit    = run_body && !is_digit && hold_ch != CH_UNDER;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      accumulator <= '0;
      base_sel    <= BASE_DEC;
      char_count  <= '0;
    end else if (advance) begin
      if (run_body) begin
        accumulator <= is_digit ? scaled + {60'd0, digit} : eff_acc;
        base_sel    <= eff_base;
        char_count  <= emit ? eff_cnt : cnt_inc;
        phase       <= emit ? PH_IDLE : PH_BODY;
      end else begin
        accumulator <= accumulator_next;
        base_sel    <= base_sel_next;
        char_count  <= char_count_next;
        phase       <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      value     <= eff_acc;
      base_code <= eff_base;
      length    <= eff_cnt;
    end
  end

  `ILP_ASSERT_NEXT(a_emit_shows, advance && emit, result_valid && phase == PH_IDLE)
  `ILP_ASSERT(a_zero_phase_clean, phase == PH_ZERO,
              accumulator == 64'd0 && char_count == 16'd1)
  `ILP_ASSERT(a_stall_has_item, char_stall, hold_valid && result_valid)

endmodule
